// ----- src/frc_pkg.sv -----
// Shared types and constants for the reply frame checker.
// No dependencies; the judge, the checker top and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package frc_pkg;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned CountW   = $clog2(FrameLen);

  localparam logic [7:0]  FrameMark    = 8'hF5;
  localparam logic [7:0]  ScanCode     = 8'h0C;
  localparam logic [7:0]  ScanAckMax   = 8'd3;
  localparam logic [15:0] TimeoutReset = 16'd9000;

  // input item commands; the fourth code is ignored
  typedef enum logic [1:0] {
    CMD_ARM  = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_TAIL    = 3'd2,
    ST_CSUM    = 3'd3,
    ST_ECHO    = 3'd4,
    ST_MODERR  = 3'd5
  } status_t;

  // configuration register indexes
  typedef enum logic {
    REG_ACK_OK  = 1'b0,
    REG_TIMEOUT = 1'b1
  } reg_idx_t;

  typedef logic [FrameLen-1:0][7:0] frame_t;

endpackage

`default_nettype wire

// ----- src/frc_in_if.sv -----
// Input item channel: valid/ready handshake with command, code and byte.
// Depends on nothing but the field widths of the checker.
`timescale 1ns / 1ps
`default_nettype none

interface frc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] expected_code;
  logic [7:0] rx_byte;

  modport source (output valid, command, expected_code, rx_byte, input ready);
  modport sink   (input valid, command, expected_code, rx_byte, output ready);
endinterface

`default_nettype wire

// ----- src/frc_out_if.sv -----
// Result item channel: valid/ready handshake with status and three params.
// Depends on nothing but the field widths of the checker.
`timescale 1ns / 1ps
`default_nettype none

interface frc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] first_param;
  logic [7:0] second_param;
  logic [7:0] third_param;

  modport source (output valid, status, first_param, second_param, third_param,
                  input ready);
  modport sink   (input valid, status, first_param, second_param, third_param,
                  output ready);
endinterface

`default_nettype wire

// ----- src/frc_judge.sv -----
// Combinational verdict on one complete 8-byte reply frame.
// Depends on frc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frc_judge (
  input  wire frc_pkg::frame_t  frame,
  input  wire logic [7:0]       wanted_code,
  input  wire logic [7:0]       ack_ok_code,
  output frc_pkg::status_t      status
);
  import frc_pkg::*;

  logic [7:0] csum;
  logic [7:0] ack;

  assign csum = frame[1] ^ frame[2] ^ frame[3] ^ frame[4] ^ frame[5];
  assign ack  = frame[4];

  // checks in priority order: tail, checksum, echo, acknowledge
  always_comb begin
    if (frame[7] != FrameMark) begin
      status = ST_TAIL;
    end else if (csum != frame[6]) begin
      status = ST_CSUM;
    end else if (frame[1] != wanted_code) begin
      status = ST_ECHO;
    end else if (ack == ack_ok_code) begin
      status = ST_OK;
    end else if (frame[1] == ScanCode && ack >= 8'd1 && ack <= ScanAckMax) begin
      status = ST_OK;   // scan reply reports a count in the ack byte
    end else begin
      status = ST_MODERR;
    end
  end

endmodule

`default_nettype wire

// ----- src/fingerprint_reply_frame_checker.sv -----
// Top level of the reply frame checker: input register, state, result register.
// Depends on frc_pkg, frc_in_if, frc_out_if and frc_judge.
//
//   channel | dir | payload                                           | handshake
//   req     | in  | command, expected_code, rx_byte                   | valid/ready
//   rsp     | out | status, first_param, second_param, third_param    | valid/ready
//   cfg     | in  | cfg_index, cfg_data                               | cfg_we, no wait
//
// One item per cycle while no result item is blocked: an accepted item is held in the input register,
// then updates the state and, if it finishes a request, loads the result register.
// Result valid is registered: it rises as the item that ends a request leaves the input register.
// rst (synchronous) disarms and restores register defaults.
// A result item that is not taken stalls only items that would produce another one.
`timescale 1ns / 1ps
`default_nettype none

module fingerprint_reply_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  frc_in_if.sink           req,
  frc_out_if.source        rsp,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  import frc_pkg::*;

  // configuration
  logic [7:0]  ack_ok_code;
  logic [15:0] timeout_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_ok_code   <= 8'd0;
      timeout_ticks <= TimeoutReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ACK_OK:  ack_ok_code   <= cfg_data[7:0];
        REG_TIMEOUT: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid;
  logic [1:0] s1_cmd;
  logic [7:0] s1_code;
  logic [7:0] s1_byte;
  logic       s1_advance;
  logic       produce;

  assign s1_advance = s1_valid && (!produce || !rsp.valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_cmd  <= req.command;
      s1_code <= req.expected_code;
      s1_byte <= req.rx_byte;
    end
  end

  // request state
  logic              armed;
  logic [7:0]        wanted_code;
  logic [CountW-1:0] byte_count;
  logic [16:0]       elapsed_ticks;
  frame_t            frame_store;

  logic              armed_next;
  logic [7:0]        wanted_code_next;
  logic [CountW-1:0] byte_count_next;
  logic [16:0]       elapsed_ticks_next;
  logic              store_byte;
  status_t           res_status;
  logic [7:0]        res_p1;
  logic [7:0]        res_p2;
  logic [7:0]        res_p3;

  frame_t  full_frame;
  status_t verdict;

  // last byte comes straight from the input register
  always_comb begin
    full_frame    = frame_store;
    full_frame[0] = FrameMark;
    full_frame[FrameLen-1] = s1_byte;
  end

  frc_judge u_judge (
    .frame       (full_frame),
    .wanted_code (wanted_code),
    .ack_ok_code (ack_ok_code),
    .status      (verdict)
  );

  always_comb begin
    armed_next         = armed;
    wanted_code_next   = wanted_code;
    byte_count_next    = byte_count;
    elapsed_ticks_next = elapsed_ticks;
    store_byte         = 1'b0;
    produce            = 1'b0;
    res_status         = verdict;
    res_p1             = frame_store[2];
    res_p2             = frame_store[3];
    res_p3             = frame_store[4];
    if (s1_valid) begin
      if (s1_cmd == CMD_ARM) begin
        armed_next         = 1'b1;
        wanted_code_next   = s1_code;
        byte_count_next    = '0;
        elapsed_ticks_next = '0;
      end else if (armed && s1_cmd == CMD_BYTE) begin
        // hunt for the start byte before collecting
        if (byte_count != '0 || s1_byte == FrameMark) begin
          store_byte      = 1'b1;
          byte_count_next = byte_count + 1'b1;
          if (byte_count == CountW'(FrameLen - 1)) begin
            produce         = 1'b1;
            armed_next      = 1'b0;
            byte_count_next = '0;
          end
        end
      end else if (armed && s1_cmd == CMD_TICK) begin
        elapsed_ticks_next = elapsed_ticks + 17'd1;
        if (elapsed_ticks_next > {1'b0, timeout_ticks}) begin
          produce         = 1'b1;
          armed_next      = 1'b0;
          byte_count_next = '0;
          res_status      = ST_TIMEOUT;
          res_p1          = 8'd0;
          res_p2          = 8'd0;
          res_p3          = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed         <= 1'b0;
      wanted_code   <= 8'd0;
      byte_count    <= '0;
      elapsed_ticks <= '0;
    end else if (s1_advance) begin
      armed         <= armed_next;
      wanted_code   <= wanted_code_next;
      byte_count    <= byte_count_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && store_byte) begin
      frame_store[byte_count] <= s1_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_advance && produce) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && produce) begin
      rsp.status       <= res_status;
      rsp.first_param  <= res_p1;
      rsp.second_param <= res_p2;
      rsp.third_param  <= res_p3;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_fingerprint_reply_frame_checker.sv -----
// Self-checking testbench for the reply frame checker: valid/ready item drivers,
// an item-level predictor and a scoreboard of expected verdicts.
// Depends on frc_pkg, frc_in_if, frc_out_if and fingerprint_reply_frame_checker.
`timescale 1ns / 1ps

module tb_fingerprint_reply_frame_checker;
  import frc_pkg::*;

  localparam logic [1:0] CmdIgnored = 2'd3;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned MaxShowFails = 10;

  typedef enum {FR_GOOD, FR_SCAN, FR_TAIL, FR_CSUM, FR_ECHO, FR_MODERR} frame_kind_t;
  typedef enum {SINK_FREE, SINK_COIN, SINK_SPARSE, SINK_BURSTY} sink_mode_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] first_param;
    logic [7:0] second_param;
    logic [7:0] third_param;
  } verdict_t;

  // Tracks the checker state and the verdicts still owed by the block.
  class frame_verdict_board;
    logic        is_armed;
    logic [7:0]  echo_code;
    logic [3:0]  held;
    frame_t      frame;
    logic [16:0] ticks;
    logic [7:0]  ack_good;
    logic [15:0] tick_limit;
    verdict_t    expected_verdicts[$];
    int          fail_count;

    function new();
      is_armed = 1'b0;
      echo_code = '0;
      held = '0;
      frame = '0;
      ticks = '0;
      ack_good = 8'h00;
      tick_limit = TimeoutReset;
      fail_count = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] value);
      if (idx == REG_ACK_OK) ack_good = value[7:0];
      else tick_limit = value;
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    function status_t judge();
      logic [7:0] x;
      x = frame[1] ^ frame[2] ^ frame[3] ^ frame[4] ^ frame[5];
      if (frame[7] != FrameMark) return ST_TAIL;
      if (x != frame[6]) return ST_CSUM;
      if (frame[1] != echo_code) return ST_ECHO;
      if (frame[4] == ack_good) return ST_OK;
      if (frame[1] == ScanCode && frame[4] >= 8'd1 && frame[4] <= ScanAckMax) return ST_OK;
      return ST_MODERR;
    endfunction

    function void note_request_item(logic [1:0] cmd, logic [7:0] code, logic [7:0] b);
      verdict_t v;
      case (cmd)
        CMD_ARM: begin
          is_armed = 1'b1;
          echo_code = code;
          held = '0;
          ticks = '0;
        end
        CMD_BYTE: begin
          // bytes before the start mark are dropped
          if (is_armed && !(held == 0 && b != FrameMark)) begin
            frame[held[2:0]] = b;
            held++;
            if (held == FrameLen) begin
              v.status = judge();
              v.first_param = frame[2];
              v.second_param = frame[3];
              v.third_param = frame[4];
              expected_verdicts.push_back(v);
              is_armed = 1'b0;
              held = '0;
            end
          end
        end
        CMD_TICK: begin
          if (is_armed) begin
            ticks++;
            if (ticks > {1'b0, tick_limit}) begin
              v.status = ST_TIMEOUT;
              v.first_param = '0;
              v.second_param = '0;
              v.third_param = '0;
              expected_verdicts.push_back(v);
              is_armed = 1'b0;
              held = '0;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string msg);
      fail_count++;
      if (fail_count <= MaxShowFails) $display("MISMATCH: %s", msg);
    endfunction

    function void check_verdict(logic [2:0] st, logic [7:0] p1, logic [7:0] p2,
                                logic [7:0] p3);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("unexpected result status %0d params %02h %02h %02h",
                         st, p1, p2, p3));
        return;
      end
      want = expected_verdicts.pop_front();
      if (st !== want.status || p1 !== want.first_param || p2 !== want.second_param ||
          p3 !== want.third_param)
        report($sformatf("expected status %0d params %02h %02h %02h, got %0d %02h %02h %02h",
                         want.status, want.first_param, want.second_param,
                         want.third_param, st, p1, p2, p3));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  frc_in_if  req();
  frc_out_if rsp();

  fingerprint_reply_frame_checker DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_verdict_board board = new();
  int unsigned cycles = 0;
  int unsigned sent_items = 0;
  int burst_left = 0;
  int tick_pct = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end else if (!rst) begin
      if (rsp.valid && rsp.ready)
        board.check_verdict(rsp.status, rsp.first_param, rsp.second_param, rsp.third_param);
      if (req.valid && req.ready)
        board.note_request_item(req.command, req.expected_code, req.rx_byte);
    end
  end

  // result side: ready follows a randomly chosen sink mode
  initial begin
    sink_mode_t mode;
    int cyc;
    rsp.ready = 1'b0;
    mode = SINK_FREE;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 300 == 0) mode = sink_mode_t'($urandom_range(0, 3));
      case (mode)
        SINK_FREE:   rsp.ready <= 1'b1;
        SINK_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: rsp.ready <= (cyc % 5 == 0);
        default:     rsp.ready <= (cyc % 16 < 11);
      endcase
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] code,
                           input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req.valid <= 1'b1;
    req.command <= cmd;
    req.expected_code <= code;
    req.rx_byte <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_raw_frame(input frame_t f);
    int i;
    for (i = 0; i < FrameLen; i++) begin
      if ($urandom_range(0, 99) < tick_pct)
        send_item(CMD_TICK, 8'($urandom), 8'($urandom));
      send_item(CMD_BYTE, 8'($urandom), f[i]);
    end
  endtask

  task automatic send_frame(input logic [7:0] code, input frame_kind_t kind, input int noise);
    frame_t f;
    logic [7:0] junk;
    int i;
    repeat (noise) begin
      junk = 8'($urandom);
      if (junk == FrameMark) junk = ~junk;
      send_item(CMD_BYTE, 8'($urandom), junk);
    end
    f[0] = FrameMark;
    f[1] = code;
    for (i = 2; i < 6; i++) f[i] = 8'($urandom);
    f[7] = FrameMark;
    case (kind)
      FR_GOOD: f[4] = board.ack_good;
      FR_SCAN: f[4] = 8'($urandom_range(1, ScanAckMax));
      FR_ECHO: f[1] = code ^ 8'($urandom_range(1, 255));
      FR_TAIL: f[7] = FrameMark ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
    f[6] = f[1] ^ f[2] ^ f[3] ^ f[4] ^ f[5];
    if (kind == FR_CSUM) f[6] ^= 8'($urandom_range(1, 255));
    send_raw_frame(f);
  endtask

  task automatic run_request(input frame_kind_t kind);
    logic [7:0] code;
    code = (kind == FR_SCAN) ? ScanCode : 8'($urandom);
    send_item(CMD_ARM, code, 8'($urandom));
    send_frame(code, kind, $urandom_range(0, 3));
  endtask

  task automatic run_to_timeout();
    int n;
    n = int'(board.tick_limit) + 1;
    send_item(CMD_ARM, 8'($urandom), 8'($urandom));
    repeat (n) send_item(CMD_TICK, 8'($urandom), 8'($urandom));
  endtask

  // drop valid, collect every owed verdict, then cover the pipeline latency
  task automatic settle();
    @(negedge clk);
    req.valid <= 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    board.set_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase;
    int pick;
    int unsigned start;
    logic [7:0] ack;
    logic [15:0] tmo;

    rst = 1'b1;
    req.valid = 1'b0;
    req.command = CMD_ARM;
    req.expected_code = 8'h00;
    req.rx_byte = 8'h00;
    cfg_we = 1'b0;
    cfg_index = REG_ACK_OK;
    cfg_data = 16'h0000;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: idle items are ignored, a re-arm drops the open request
    send_item(CMD_TICK, 8'h00, 8'h00);
    send_item(CMD_BYTE, 8'hFF, FrameMark);
    send_item(CmdIgnored, 8'hA5, 8'h5A);
    send_item(CMD_ARM, 8'hFF, 8'h00);
    send_item(CMD_BYTE, 8'h00, FrameMark);
    send_item(CMD_BYTE, 8'h00, 8'hFF);
    send_item(CMD_ARM, ScanCode, 8'hFF);
    send_frame(ScanCode, FR_SCAN, 2);
    send_item(CMD_ARM, 8'h00, 8'h00);
    send_raw_frame({FrameMark, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, FrameMark});
    // ticks well under the reset timeout leave the request open
    send_item(CMD_ARM, 8'h5A, 8'h00);
    repeat (40) send_item(CMD_TICK, 8'h00, 8'h00);
    settle();

    // zero timeout: first tick after arming expires
    write_reg(REG_ACK_OK, 16'h00FF);
    write_reg(REG_TIMEOUT, 16'h0000);
    run_to_timeout();
    run_request(FR_GOOD);
    settle();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin ack = 8'h00; tmo = 16'd1; end
        1: begin ack = 8'hFF; tmo = 16'hFFFF; end
        2: begin ack = 8'($urandom); tmo = 16'($urandom_range(2, 30)); end
        3: begin ack = 8'($urandom); tmo = 16'($urandom); end
        4: begin ack = 8'($urandom_range(0, 3)); tmo = 16'($urandom_range(0, 12)); end
        default: begin ack = 8'($urandom); tmo = TimeoutReset; end
      endcase
      write_reg(REG_ACK_OK, {8'h00, ack});
      write_reg(REG_TIMEOUT, tmo);
      tick_pct = $urandom_range(0, 10);
      start = sent_items;
      while (sent_items - start < PhaseItems) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          run_request(frame_kind_t'($urandom_range(0, 5)));
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 4))
            send_item(2'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 92 && board.tick_limit <= 40) begin
          run_to_timeout();
        end else begin
          // partial frame, left open for the next arm to drop
          send_item(CMD_ARM, 8'($urandom), 8'($urandom));
          send_item(CMD_BYTE, 8'($urandom), FrameMark);
          repeat ($urandom_range(0, 6)) send_item(CMD_BYTE, 8'($urandom), 8'($urandom));
        end
      end
      settle();
    end

    if (board.fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ----- fingerprint_reply_frame_checker.f -----
src/frc_pkg.sv
src/frc_in_if.sv
src/frc_out_if.sv
src/frc_judge.sv
src/fingerprint_reply_frame_checker.sv
tb/tb_fingerprint_reply_frame_checker.sv
